@@ rtl/svalloc_pkg.sv @@
package svalloc_pkg;

	// request codes
	localparam logic [2:0] REQ_NOTE_ON    = 3'd0;
	localparam logic [2:0] REQ_NOTE_OFF   = 3'd1;
	localparam logic [2:0] REQ_SET_VEL    = 3'd2;
	localparam logic [2:0] REQ_SET_FX     = 3'd3;
	localparam logic [2:0] REQ_STOP_ALL   = 3'd4;
	localparam logic [2:0] REQ_VOICE_DONE = 3'd5;

	// field widths
	localparam int REQ_W    = 3;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 16;
	localparam int STAMP_W  = 32;
	localparam int KIND_W   = 4;
	localparam int AMOUNT_W = 16;
	localparam int DONE_W   = 4;
	localparam int OUT_IDX_W = 4;
	localparam int POLY_W   = 5;

	// effect kind loaded into both slots on note-on
	localparam logic [KIND_W-1:0] FX_DEFAULT_KIND = 4'hF;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic steal;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} sts_t;

endpackage

@@ rtl/svalloc_ctrl.sv @@
module svalloc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  svalloc_pkg::sts_t  sts,
	output svalloc_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_STEAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.scan_start = (state_q == ST_EVAL) && sts.need_scan;
		cmd.scan_step  = (state_q == ST_SCAN);
		cmd.steal      = (state_q == ST_STEAL);
		cmd.commit     = out_free && (((state_q == ST_EVAL) && !sts.need_scan) ||
			(state_q == ST_STEAL));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.need_scan) begin
						state_q <= ST_SCAN;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_STEAL;
					end
				end
				ST_STEAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result is only loaded when the output register can take it
	a_commit_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	// a new result appears only after a commit
	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("output valid rose without a commit");

	// the scan finishes only while scanning
	a_scan_last_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.scan_last |-> (state_q == ST_SCAN))
		else $error("scan end outside scan state");

endmodule

@@ rtl/svalloc_dpath.sv @@
module svalloc_dpath #(
	parameter int VOICE_COUNT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svalloc_pkg::cmd_t                    cmd,
	output svalloc_pkg::sts_t                    sts,
	input  logic                                 cfg_write,
	input  logic [svalloc_pkg::POLY_W-1:0]       polyphony,
	input  logic [svalloc_pkg::REQ_W-1:0]        req_type,
	input  logic [svalloc_pkg::NOTE_W-1:0]       note_number,
	input  logic [svalloc_pkg::VEL_W-1:0]        note_velocity,
	input  logic [svalloc_pkg::STAMP_W-1:0]      start_stamp,
	input  logic                                 effect_slot,
	input  logic [svalloc_pkg::KIND_W-1:0]       effect_kind,
	input  logic [svalloc_pkg::AMOUNT_W-1:0]     effect_amount,
	input  logic [svalloc_pkg::DONE_W-1:0]       done_voice,
	output logic [svalloc_pkg::OUT_IDX_W-1:0]    voice_index,
	output logic                                 voice_found,
	output logic                                 voice_stolen
);

	localparam int IW = $clog2(VOICE_COUNT);
	localparam int CW = $clog2(VOICE_COUNT + 1);
	localparam int DW = (IW > svalloc_pkg::DONE_W) ? IW : svalloc_pkg::DONE_W;
	localparam int XW = (IW > svalloc_pkg::OUT_IDX_W) ? IW : svalloc_pkg::OUT_IDX_W;

	// captured request
	logic [svalloc_pkg::REQ_W-1:0]    req_type_q;
	logic [svalloc_pkg::NOTE_W-1:0]   req_note_q;
	logic [svalloc_pkg::VEL_W-1:0]    req_vel_q;
	logic [svalloc_pkg::STAMP_W-1:0]  req_stamp_q;
	logic                             req_slot_q;
	logic [svalloc_pkg::KIND_W-1:0]   req_kind_q;
	logic [svalloc_pkg::AMOUNT_W-1:0] req_amount_q;
	logic [svalloc_pkg::DONE_W-1:0]   req_done_q;

	// voice table
	logic [CW-1:0]          voices_q;
	logic [VOICE_COUNT-1:0] voice_active_q;
	logic [VOICE_COUNT-1:0] voice_released_q;
	logic [svalloc_pkg::NOTE_W-1:0] voice_note_q [VOICE_COUNT];
	logic [svalloc_pkg::VEL_W-1:0]   vel_mem    [VOICE_COUNT];
	logic [svalloc_pkg::STAMP_W-1:0] start_mem  [VOICE_COUNT];
	logic [1:0][svalloc_pkg::KIND_W-1:0]   kind_mem   [VOICE_COUNT];
	logic [1:0][svalloc_pkg::AMOUNT_W-1:0] amount_mem [VOICE_COUNT];

	// oldest scan
	logic [IW-1:0]                   scan_addr_q;
	logic                            rd_vld_q;
	logic [IW-1:0]                   rd_idx_q;
	logic [svalloc_pkg::STAMP_W-1:0] start_rd_q;
	logic [svalloc_pkg::STAMP_W-1:0] best_q;
	logic [IW-1:0]                   best_idx_q;

	// output register
	logic [svalloc_pkg::OUT_IDX_W-1:0] voice_index_q;
	logic                              voice_found_q;
	logic                              voice_stolen_q;

	logic [VOICE_COUNT-1:0] range_mask;
	logic [VOICE_COUNT-1:0] keep_mask;
	logic [CW-1:0]          voices_new;
	logic [CW-1:0]          last_voice;
	logic                   free_found;
	logic [IW-1:0]          free_idx;
	logic                   match_found;
	logic [IW-1:0]          match_idx;
	logic [DW-1:0]          done_ext;
	logic [IW-1:0]          done_idx;
	logic                   done_ok;
	logic [IW-1:0]          sel_idx;
	logic [XW-1:0]          res_idx_ext;
	logic                   res_found;
	logic                   res_stolen;
	logic                   we_on;
	logic                   we_off;
	logic                   we_vel;
	logic                   we_fx;
	logic                   clr_all;
	logic                   clr_done;

	// clamp written polyphony into 1..VOICE_COUNT
	always_comb begin
		if (polyphony == '0) begin
			voices_new = CW'(1);
		end else if (32'(polyphony) > VOICE_COUNT) begin
			voices_new = CW'(VOICE_COUNT);
		end else begin
			voices_new = CW'(polyphony);
		end
	end

	always_comb begin
		for (int i = 0; i < VOICE_COUNT; i++) begin
			range_mask[i] = (CW'(i) < voices_q);
			keep_mask[i]  = (CW'(i) < voices_new);
		end
	end

	assign last_voice = voices_q - CW'(1);

	// first free and first matching voice in range
	always_comb begin
		free_found  = 1'b0;
		free_idx    = '0;
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (range_mask[i] && !voice_active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (range_mask[i] && voice_active_q[i] && !voice_released_q[i] &&
				(voice_note_q[i] == req_note_q)) begin
				match_found = 1'b1;
				match_idx   = IW'(i);
			end
		end
	end

	assign done_ext = DW'(req_done_q);
	assign done_idx = done_ext[IW-1:0];
	assign done_ok  = (32'(req_done_q) < VOICE_COUNT);

	assign sts.need_scan = (req_type_q == svalloc_pkg::REQ_NOTE_ON) && !free_found &&
		!cmd.steal;
	assign sts.scan_last = cmd.scan_step && rd_vld_q && (CW'(rd_idx_q) == last_voice);

	// decode of the commit
	always_comb begin
		sel_idx     = match_idx;
		res_idx_ext = '0;
		res_found   = 1'b0;
		res_stolen  = 1'b0;
		we_on       = 1'b0;
		we_off      = 1'b0;
		we_vel      = 1'b0;
		we_fx       = 1'b0;
		clr_all     = 1'b0;
		clr_done    = 1'b0;
		case (req_type_q)
			svalloc_pkg::REQ_NOTE_ON: begin
				sel_idx     = cmd.steal ? best_idx_q : free_idx;
				we_on       = cmd.commit;
				res_idx_ext = XW'(sel_idx);
				res_found   = 1'b1;
				res_stolen  = cmd.steal;
			end
			svalloc_pkg::REQ_NOTE_OFF: begin
				we_off      = cmd.commit && match_found;
				res_idx_ext = match_found ? XW'(match_idx) : '0;
				res_found   = match_found;
			end
			svalloc_pkg::REQ_SET_VEL: begin
				we_vel      = cmd.commit && match_found;
				res_idx_ext = match_found ? XW'(match_idx) : '0;
				res_found   = match_found;
			end
			svalloc_pkg::REQ_SET_FX: begin
				we_fx       = cmd.commit && match_found;
				res_idx_ext = match_found ? XW'(match_idx) : '0;
				res_found   = match_found;
			end
			svalloc_pkg::REQ_STOP_ALL: begin
				clr_all = cmd.commit;
			end
			svalloc_pkg::REQ_VOICE_DONE: begin
				sel_idx     = done_idx;
				clr_done    = cmd.commit && done_ok;
				res_idx_ext = done_ok ? XW'(req_done_q) : '0;
				res_found   = done_ok && voice_active_q[done_idx];
			end
			default: begin
				res_idx_ext = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q   <= req_type;
			req_note_q   <= note_number;
			req_vel_q    <= note_velocity;
			req_stamp_q  <= start_stamp;
			req_slot_q   <= effect_slot;
			req_kind_q   <= effect_kind;
			req_amount_q <= effect_amount;
			req_done_q   <= done_voice;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voices_q         <= CW'(1);
			voice_active_q   <= '0;
			voice_released_q <= '0;
		end else begin
			if (cfg_write) begin
				voices_q       <= voices_new;
				voice_active_q <= voice_active_q & keep_mask;
			end else if (clr_all) begin
				voice_active_q <= '0;
			end else if (clr_done) begin
				voice_active_q[sel_idx] <= 1'b0;
			end else if (we_on) begin
				voice_active_q[sel_idx]   <= 1'b1;
				voice_released_q[sel_idx] <= 1'b0;
			end else if (we_off) begin
				voice_released_q[sel_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_on) begin
			voice_note_q[sel_idx] <= req_note_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_on || we_vel) begin
			vel_mem[sel_idx] <= req_vel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_on) begin
			start_mem[sel_idx] <= req_stamp_q;
		end
		start_rd_q <= start_mem[scan_addr_q];
	end

	always_ff @(posedge clk) begin
		if (we_on) begin
			kind_mem[sel_idx] <= {svalloc_pkg::FX_DEFAULT_KIND, svalloc_pkg::FX_DEFAULT_KIND};
		end else if (we_fx) begin
			kind_mem[sel_idx][req_slot_q] <= req_kind_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_fx) begin
			amount_mem[sel_idx][req_slot_q] <= req_amount_q;
		end
	end

	// oldest search, one start time per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rd_vld_q    <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_addr_q <= '0;
			rd_vld_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_addr_q <= scan_addr_q + IW'(1);
			rd_vld_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_idx_q <= scan_addr_q;
			if (rd_vld_q && ((rd_idx_q == '0) || (start_rd_q < best_q))) begin
				best_q     <= start_rd_q;
				best_idx_q <= rd_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			voice_index_q  <= res_idx_ext[svalloc_pkg::OUT_IDX_W-1:0];
			voice_found_q  <= res_found;
			voice_stolen_q <= res_stolen;
		end
	end

	assign voice_index  = voice_index_q;
	assign voice_found  = voice_found_q;
	assign voice_stolen = voice_stolen_q;

	// voices beyond the polyphony never stay active
	a_active_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(voice_active_q & ~range_mask) == '0)
		else $error("active voice beyond polyphony");

	// a note-on leaves its voice sounding and unreleased
	a_note_on_sets: assert property (@(posedge clk) disable iff (!arst_n)
		we_on |=> (voice_active_q[$past(sel_idx)] && !voice_released_q[$past(sel_idx)]))
		else $error("note-on did not claim its voice");

	// stealing only happens with every voice in range busy
	a_steal_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && cmd.steal) |-> !free_found)
		else $error("steal while a voice was free");

endmodule

@@ rtl/synth_voice_allocator.sv @@
// polyphonic voice allocator with oldest-voice stealing. keeps a table of
// VOICE_COUNT voices of which the first `polyphony` (clamped to 1..VOICE_COUNT)
// take part. a note-on claims the lowest free voice in range or, with all of
// them busy, steals the one with the smallest start stamp (lowest index on a
// tie) and resets both effect kinds to 15; note-off, velocity and effect
// requests act on the lowest active, unreleased voice holding the note;
// stop-all and voice-done clear active flags. every request gives exactly one
// result (index, found, stolen). a request is captured, then searched and
// written back through a single shared search stage; a new request is taken
// only once the last one is written back. a note-on that must steal first
// scans the start times of the voices in range, one voice per cycle, from
// the memory's single registered read port. the output register lets
// the next request be taken while a result waits; a request only finishes
// once that register is free. polyphony writes are accepted at any time but
// must only be issued while the block is idle; lowering it silences voices
// above the new limit.
module synth_voice_allocator #(
	parameter int VOICE_COUNT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svalloc_pkg::POLY_W-1:0]       polyphony,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [svalloc_pkg::REQ_W-1:0]        req_type,
	input  logic [svalloc_pkg::NOTE_W-1:0]       note_number,
	input  logic [svalloc_pkg::VEL_W-1:0]        note_velocity,
	input  logic [svalloc_pkg::STAMP_W-1:0]      start_stamp,
	input  logic                                 effect_slot,
	input  logic [svalloc_pkg::KIND_W-1:0]       effect_kind,
	input  logic [svalloc_pkg::AMOUNT_W-1:0]     effect_amount,
	input  logic [svalloc_pkg::DONE_W-1:0]       done_voice,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [svalloc_pkg::OUT_IDX_W-1:0]    voice_index,
	output logic                                 voice_found,
	output logic                                 voice_stolen
);

	svalloc_pkg::cmd_t cmd;
	svalloc_pkg::sts_t sts;

	// the polyphony register is always writable
	assign cfg_ready = 1'b1;

	// sequencer: capture, search, optional oldest scan, write-back
	svalloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// voice table, searches and result register
	svalloc_dpath #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_valid && cfg_ready),
		.polyphony     (polyphony),
		.req_type      (req_type),
		.note_number   (note_number),
		.note_velocity (note_velocity),
		.start_stamp   (start_stamp),
		.effect_slot   (effect_slot),
		.effect_kind   (effect_kind),
		.effect_amount (effect_amount),
		.done_voice    (done_voice),
		.voice_index   (voice_index),
		.voice_found   (voice_found),
		.voice_stolen  (voice_stolen)
	);

endmodule
